>>> sv/fbtp_pkg.sv
// ----------------------------------------------------------------------------
// fbtp_pkg
// Shared types and constants for the float byte truncation packer.
// ----------------------------------------------------------------------------
package fbtp_pkg;

	localparam int unsigned WORD_BYTES = 4;
	localparam int unsigned WORD_W     = 8 * WORD_BYTES;
	localparam int unsigned PEND_W     = 8 * (WORD_BYTES - 1);
	localparam int unsigned KEEP_W     = 6;
	localparam int unsigned VB_W       = 3;
	localparam int unsigned CNT_W      = 2;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 6'd32;

	typedef struct packed {
		logic [WORD_W-1:0] packed_word;
		logic [VB_W-1:0]   valid_bytes;
		logic              final_word;
	} result_t;

	typedef struct packed {
		logic              full_v;
		result_t           full_res;
		logic              flush_v;
		result_t           flush_res;
		logic [PEND_W-1:0] pend_bytes;
		logic [CNT_W-1:0]  pend_count;
	} merge_t;

endpackage

>>> sv/fbtp_merge.sv
// ----------------------------------------------------------------------------
// fbtp_merge
// Cuts one float to its upper bytes and merges them behind the held bytes.
// ----------------------------------------------------------------------------
module fbtp_merge (
	input  logic [31:0]                   value_bits,
	input  logic                          last_value,
	input  logic [fbtp_pkg::KEEP_W-1:0]   kept_bits,
	input  logic [fbtp_pkg::PEND_W-1:0]   pend_bytes,
	input  logic [fbtp_pkg::CNT_W-1:0]    pend_count,
	output fbtp_pkg::merge_t              merge
);

	logic [2:0]  n_keep;
	logic [1:0]  drop;
	logic [31:0] kept;
	logic [55:0] merged;
	logic [55:0] rem;
	logic [2:0]  total;
	logic [2:0]  total2;
	logic        full;
	logic [23:0] mask;
	logic [23:0] rem_masked;
	logic [6:0]  k_round;

	always_comb begin
		k_round = {1'b0, kept_bits} + 7'd7;
		if (kept_bits == '0) begin
			n_keep = 3'd1;
		end else if (kept_bits >= 6'd25) begin
			n_keep = 3'd4;
		end else begin
			n_keep = k_round[5:3];
		end
		drop   = 2'(3'd4 - n_keep);
		kept   = value_bits >> {drop, 3'b000};
		merged = {32'd0, pend_bytes} | ({24'd0, kept} << {pend_count, 3'b000});
		total  = {1'b0, pend_count} + n_keep;
		full   = total[2];
		rem    = full ? (merged >> 32) : merged;
		total2 = full ? {1'b0, total[1:0]} : total;
		case (total2[1:0])
			2'd0:    mask = 24'h000000;
			2'd1:    mask = 24'h0000FF;
			2'd2:    mask = 24'h00FFFF;
			default: mask = 24'hFFFFFF;
		endcase
		rem_masked = rem[23:0] & mask;

		merge.full_v                = full;
		merge.full_res.packed_word  = merged[31:0];
		merge.full_res.valid_bytes  = 3'd4;
		merge.full_res.final_word   = last_value && (total2 == 3'd0);
		merge.flush_v               = last_value && (total2 != 3'd0);
		merge.flush_res.packed_word = {8'd0, rem_masked};
		merge.flush_res.valid_bytes = total2;
		merge.flush_res.final_word  = 1'b1;
		merge.pend_bytes            = last_value ? '0 : rem_masked;
		merge.pend_count            = last_value ? '0 : total2[1:0];
	end

endmodule

>>> sv/float_byte_truncation_packer.sv
// ----------------------------------------------------------------------------
// float_byte_truncation_packer
// Packs the upper bytes of float words into a dense stream of 32-bit words.
// ----------------------------------------------------------------------------
// Path: an accepted word is registered in s1, merged, and queued for output.
// Throughput: one input word per cycle while out_ready holds and each
//   yields at most one output word; a last word may emit a full and a flush word.
// Reset: arst_n clears held bytes, output queue and sets kept_bits to 32.
// ----------------------------------------------------------------------------
module float_byte_truncation_packer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fbtp_pkg::KEEP_W-1:0]   kept_bits,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [31:0]                   value_bits,
	input  logic                          last_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [31:0]                   packed_word,
	output logic [2:0]                    valid_bytes,
	output logic                          final_word
);

	logic [fbtp_pkg::KEEP_W-1:0] kept_bits_q;
	logic                        valid_s1;
	logic [31:0]                 value_s1;
	logic                        last_s1;
	logic [fbtp_pkg::PEND_W-1:0] pend_bytes_q;
	logic [fbtp_pkg::CNT_W-1:0]  pend_count_q;
	fbtp_pkg::result_t           ent0_q;
	fbtp_pkg::result_t           ent1_q;
	logic [1:0]                  cnt_q;
	fbtp_pkg::merge_t            merge;
	fbtp_pkg::result_t           rem0;
	fbtp_pkg::result_t           push0;
	fbtp_pkg::result_t           push1;
	fbtp_pkg::result_t           ent0_d;
	fbtp_pkg::result_t           ent1_d;
	logic                        pop;
	logic [1:0]                  rem_cnt;
	logic [1:0]                  n_push;
	logic [2:0]                  need;
	logic                        consume;

	fbtp_merge u_merge (
		.value_bits (value_s1),
		.last_value (last_s1),
		.kept_bits  (kept_bits_q),
		.pend_bytes (pend_bytes_q),
		.pend_count (pend_count_q),
		.merge      (merge)
	);

	assign cfg_ready   = 1'b1;
	assign out_valid   = (cnt_q != 2'd0);
	assign packed_word = ent0_q.packed_word;
	assign valid_bytes = ent0_q.valid_bytes;
	assign final_word  = ent0_q.final_word;
	assign in_ready    = !valid_s1 || consume;

	always_comb begin
		pop     = out_valid && out_ready;
		rem_cnt = cnt_q - {1'b0, pop};
		rem0    = pop ? ent1_q : ent0_q;
		n_push  = {1'b0, merge.full_v} + {1'b0, merge.flush_v};
		push0   = merge.full_v ? merge.full_res : merge.flush_res;
		push1   = merge.flush_res;
		need    = {1'b0, rem_cnt} + {1'b0, n_push};
		consume = valid_s1 && (need <= 3'd2);
		ent0_d  = rem0;
		ent1_d  = ent1_q;
		if (consume) begin
			if (rem_cnt == 2'd0) begin
				ent0_d = push0;
				ent1_d = push1;
			end else if (rem_cnt == 2'd1) begin
				ent1_d = push0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_bits_q  <= fbtp_pkg::KEEP_RESET;
			valid_s1     <= 1'b0;
			pend_bytes_q <= '0;
			pend_count_q <= '0;
			cnt_q        <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				kept_bits_q <= kept_bits;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (consume) begin
				pend_bytes_q <= merge.pend_bytes;
				pend_count_q <= merge.pend_count;
				cnt_q        <= 2'(need);
			end else begin
				cnt_q <= rem_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			value_s1 <= value_bits;
			last_s1  <= last_value;
		end
		ent0_q <= ent0_d;
		ent1_q <= ent1_d;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue count out of range");

	a_vb_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (valid_bytes != 3'd0 && valid_bytes <= 3'd4))
		else $error("valid_bytes out of range");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && last_s1) |=> (pend_count_q == 2'd0 && pend_bytes_q == '0))
		else $error("held bytes not cleared after last word");

	a_partial_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && valid_bytes != 3'd4) |-> final_word)
		else $error("partial word without final mark");

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the float byte truncation packer. Directed streams cover
// the full and saturated widths, single-byte packing, exact word fills and
// split flushes. Random streams follow with random payloads, stream lengths
// and kept widths. A predictor tracks the held bytes and queues the packed
// words that each accepted float should produce. A monitor checks every
// output word against the oldest queued word. Input gaps and output stalls
// are random throughout.
// ----------------------------------------------------------------------------
module tb;
	import fbtp_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE       = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 900;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [KEEP_W-1:0]   kept_bits;
	logic                in_valid;
	logic                in_ready;
	logic [31:0]         value_bits;
	logic                last_value;
	logic                out_valid;
	logic                out_ready;
	logic [31:0]         packed_word;
	logic [2:0]          valid_bytes;
	logic                final_word;

	result_t             expected_words[$];
	logic [KEEP_W-1:0]   keep_setting;
	logic [PEND_W-1:0]   held_bytes;
	int unsigned         held_count;
	int                  mismatches;
	int                  cycle_count;
	int                  floats_sent;
	int                  stall_left;
	bit                  sender_steady;
	bit                  receiver_steady;

	float_byte_truncation_packer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.kept_bits  (kept_bits),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value_bits (value_bits),
		.last_value (last_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.packed_word(packed_word),
		.valid_bytes(valid_bytes),
		.final_word (final_word)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic int unsigned bytes_kept(input logic [KEEP_W-1:0] keep);
		int unsigned k;
		int unsigned n;
		k = (keep == '0) ? 1 : keep;
		n = (k + 7) / 8;
		return (n > WORD_BYTES) ? WORD_BYTES : n;
	endfunction

	function automatic void pack_value(input logic [31:0] v, input logic lst);
		int unsigned n;
		int unsigned total;
		int unsigned rest;
		logic [63:0] merged;
		logic [63:0] mask;
		result_t     word;
		n      = bytes_kept(keep_setting);
		merged = 64'(held_bytes) | (64'(v >> (8 * (WORD_BYTES - n))) << (8 * held_count));
		total  = held_count + n;
		if (total >= WORD_BYTES) begin
			rest             = total - WORD_BYTES;
			word.packed_word = merged[31:0];
			word.valid_bytes = 3'd4;
			word.final_word  = lst && (rest == 0);
			expected_words.push_back(word);
			merged = merged >> 32;
			total  = rest;
		end
		mask = (64'd1 << (8 * total)) - 64'd1;
		if (lst) begin
			if (total > 0) begin
				word.packed_word = 32'(merged & mask);
				word.valid_bytes = 3'(total);
				word.final_word  = 1'b1;
				expected_words.push_back(word);
			end
			held_bytes = '0;
			held_count = 0;
		end else begin
			held_bytes = PEND_W'(merged & mask);
			held_count = total;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (sender_steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch: %s got %h expected %h", what, got, want);
		mismatches++;
	endtask

	task automatic send_value(input logic [31:0] v, input logic lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		value_bits <= v;
		last_value <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pack_value(v, lst);
		floats_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_keep(input logic [KEEP_W-1:0] keep);
		wait_drained();
		cfg_valid <= 1'b1;
		kept_bits <= keep;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid    <= 1'b0;
		keep_setting = keep;
		@(posedge clk);
	endtask

	task automatic test_full_width();
		send_value(32'h0000_0000, 1'b0);
		send_value(32'hFFFF_FFFF, 1'b0);
		send_value(32'h8000_0000, 1'b0);
		send_value(32'h7FFF_FFFF, 1'b1);
	endtask

	task automatic test_keep_extremes();
		write_keep(6'd0);
		send_value(32'hA5C3_0001, 1'b0);
		send_value(32'h0080_0000, 1'b0);
		send_value(32'hFF00_00FF, 1'b1);
		write_keep(6'd63);
		send_value(32'h3F80_0000, 1'b0);
		send_value(32'hC2F6_E979, 1'b1);
		write_keep(6'd8);
		send_value(32'h1100_0000, 1'b0);
		send_value(32'h2200_0000, 1'b0);
		send_value(32'h3300_0000, 1'b0);
		send_value(32'h4400_0000, 1'b1);
	endtask

	task automatic test_flush_split();
		write_keep(6'd24);
		send_value(32'h0102_0304, 1'b0);
		send_value(32'hF0E0_D0C0, 1'b1);
		write_keep(6'd16);
		send_value(32'hDEAD_BEEF, 1'b1);
		write_keep(6'd9);
		send_value(32'h1234_5678, 1'b0);
		send_value(32'h9ABC_DEF0, 1'b0);
		send_value(32'h0F0F_F0F0, 1'b1);
	endtask

	task automatic test_drain_pause();
		write_keep(6'd17);
		send_value(32'hCAFE_F00D, 1'b0);
		send_value(32'h5555_AAAA, 1'b0);
		wait_drained();
		send_value(32'hAAAA_5555, 1'b0);
		send_value(32'h0000_FFFF, 1'b1);
	endtask

	task automatic test_random_streams();
		logic [KEEP_W-1:0] extremes[12];
		logic [31:0]       v;
		int                phase;
		int                streams;
		int                len;
		int                goal;
		bit                closed;
		extremes = '{6'd0, 6'd63, 6'd1, 6'd32, 6'd8, 6'd9, 6'd16, 6'd17,
			6'd24, 6'd25, 6'd7, 6'd33};
		goal  = floats_sent + RANDOM_ITEMS;
		phase = 0;
		while (floats_sent < goal) begin
			write_keep((phase < 12) ? extremes[phase] : KEEP_W'($urandom_range(0, 63)));
			sender_steady = ($urandom_range(0, 3) == 0);
			streams       = $urandom_range(1, 4);
			repeat (streams) begin
				len    = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3)
					: $urandom_range(1, 60);
				closed = ($urandom_range(0, 99) < 85);
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(0, 9))
						0:       v = 32'hFFFF_FFFF;
						1:       v = 32'h0000_0000;
						2:       v = 32'd1 << $urandom_range(0, 31);
						default: v = $urandom;
					endcase
					if (phase % 5 == 4 && i == len / 2)
						wait_drained();
					send_value(v, closed && (i == len - 1));
				end
			end
			phase++;
		end
		sender_steady = 1'b0;
	endtask

	always @(posedge clk) begin
		int r;
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (receiver_steady) begin
			out_ready <= 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				out_ready <= 1'b1;
			end else if (r < 96) begin
				out_ready  <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				out_ready  <= 1'b0;
				stall_left = $urandom_range(10, 40);
			end
		end
		if ($urandom_range(0, 199) == 0)
			receiver_steady = !receiver_steady;
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				report("unexpected word", packed_word, 32'h0);
			end else begin
				want = expected_words.pop_front();
				if (packed_word !== want.packed_word)
					report("packed_word", packed_word, want.packed_word);
				if (valid_bytes !== want.valid_bytes)
					report("valid_bytes", 32'(valid_bytes), 32'(want.valid_bytes));
				if (final_word !== want.final_word)
					report("final_word", 32'(final_word), 32'(want.final_word));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** float_byte_truncation_packer: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n          <= 1'b0;
		cfg_valid       <= 1'b0;
		kept_bits       <= KEEP_RESET;
		in_valid        <= 1'b0;
		value_bits      <= '0;
		last_value      <= 1'b0;
		out_ready       <= 1'b0;
		keep_setting    = KEEP_RESET;
		held_bytes      = '0;
		held_count      = 0;
		mismatches      = 0;
		cycle_count     = 0;
		floats_sent     = 0;
		stall_left      = 0;
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_full_width();
		test_keep_extremes();
		test_flush_split();
		test_drain_pause();
		test_random_streams();
		wait_drained();

		if (mismatches == 0)
			$display("** float_byte_truncation_packer: PASSED **");
		else
			$display("** float_byte_truncation_packer: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
sv/fbtp_pkg.sv
sv/fbtp_merge.sv
sv/float_byte_truncation_packer.sv
verif/tb.sv
